@@ hw/rtl/first_fit_block_allocator_assert.svh @@
// Assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FFBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ffba_pkg.sv @@
// Shared types and constants of the first-fit block allocator
package ffba_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 64;
    localparam logic [31:0] CHUNK_RESET    = 32'd67108864;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_CHUNK = 1'b0,
        REG_NONE  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic        free;
        logic [31:0] len;
        logic [31:0] off;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t data;
    } tab_wr_t;

    typedef struct packed {
        logic init;
        logic busy;
    } seq_stat_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_UP_RD,
        S_UP_WR,
        S_ALLOC_WR,
        S_ALLOC_WR2,
        S_MRG_RD,
        S_MRG_CHK,
        S_DN_RD,
        S_DN_WR,
        S_FREE_WR,
        S_RESP
    } state_t;

endpackage

@@ hw/rtl/first_fit_block_allocator.sv @@
// First-fit block allocator: top level with register port and assertions
//
// Keeps one chunk as an ordered table of blocks (offset, length, free mark).
// Request channel: in_valid/in_ready with command, request_bytes and
// block_offset_in; command selects allocate or free. Result channel:
// out_valid/out_ready with status, granted_offset and granted_bytes, one
// transfer per request. Register port: APB-style, chunk_bytes at address 0;
// writing it rebuilds the table as one free block of that size.
// A request scans the table entry by entry, moves entries up when a remainder
// is inserted or down when a merged block is removed, then writes back any
// change and issues the result. Each merged block shifts the rest of the
// table down one entry. The table is visited one entry per step.
// in_ready is high only while the sequencer is idle, which it enters as the
// result is loaded into the output register; the result sits there, so the
// next request can be taken while it waits.
// If the receiver stalls, the next result is held until the output frees.
// Reset sets chunk_bytes to 64 MiB; the sequencer writes entry zero in its
// init state before the first request is taken.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] request_bytes,
    input  logic [31:0] block_offset_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] granted_offset,
    output logic [31:0] granted_bytes
);

    `include "first_fit_block_allocator_assert.svh"

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

    logic [31:0]   chunk_reg, chunk_next;
    logic          cfg_wr, reinit;
    logic [IW-1:0] rd_addr, wr_addr;
    entry_t        rd_data;
    tab_wr_t       wr;
    logic [CW-1:0] count;
    seq_stat_t     stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign reinit = cfg_wr && (reg_idx_t'(paddr[2]) == REG_CHUNK);
    assign prdata = (reg_idx_t'(paddr[2]) == REG_CHUNK) ? chunk_reg : '0;

    always_comb
    begin
        chunk_next = chunk_reg;
        if (reinit)
            chunk_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chunk_reg <= CHUNK_RESET;
        else
            chunk_reg <= chunk_next;
    end

    ffba_table #(.DEPTH(MAX_BLOCKS), .AW(IW)) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_addr (wr_addr),
        .wr      (wr)
    );

    ffba_seq #(.MAX_BLOCKS(MAX_BLOCKS), .IW(IW), .CW(CW)) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .reinit          (reinit),
        .chunk           (chunk_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .request_bytes   (request_bytes),
        .block_offset_in (block_offset_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_offset  (granted_offset),
        .granted_bytes   (granted_bytes),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .wr_addr         (wr_addr),
        .wr              (wr),
        .count           (count),
        .stat            (stat)
    );

    `FFBA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready && stat.busy,
        "sequencer still ready after taking a request")
    `FFBA_ASSERT_NOW(a_count_range, 1'b1, (count != '0) && (count <= CW'(MAX_BLOCKS)),
        "block count out of range")
    `FFBA_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(stat.busy) && !$past(stat.init),
        "result raised without a request in work")

endmodule

@@ hw/rtl/ffba_table.sv @@
// Block table memory: one write port, one registered read port
module ffba_table
    import ffba_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_BLOCKS_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic [AW-1:0] wr_addr,
    input  tab_wr_t       wr
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/ffba_seq.sv @@
// Sequencer: scans, shifts and rewrites the block table one entry per step
module ffba_seq
    import ffba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int unsigned IW = $clog2(MAX_BLOCKS),
    parameter int unsigned CW = $clog2(MAX_BLOCKS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          reinit,
    input  logic [31:0]   chunk,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          command,
    input  logic [31:0]   request_bytes,
    input  logic [31:0]   block_offset_in,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic [31:0]   granted_offset,
    output logic [31:0]   granted_bytes,
    output logic [IW-1:0] rd_addr,
    input  entry_t        rd_data,
    output logic [IW-1:0] wr_addr,
    output tab_wr_t       wr,
    output logic [CW-1:0] count,
    output seq_stat_t     stat
);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] j_reg, j_next;
    cmd_t          cmd_reg, cmd_next;
    logic [31:0]   want_reg, want_next;
    logic [31:0]   key_reg, key_next;
    entry_t        cur_reg, cur_next;
    status_t       res_st_reg, res_st_next;
    logic [31:0]   res_off_reg, res_off_next;
    logic [31:0]   res_len_reg, res_len_next;
    logic          ov_reg, ov_next;
    status_t       ost_reg, ost_next;
    logic [31:0]   ooff_reg, ooff_next;
    logic [31:0]   olen_reg, olen_next;

    logic [CW:0]   idx1, cnt_x, j_x;
    logic [CW-1:0] j_m1, j_p1, idx_p1;
    logic          accept, fit, exact, hit, scan_end, full, out_free;

    assign accept   = in_valid && in_ready;
    assign idx1     = {1'b0, idx_reg} + 1'b1;
    assign cnt_x    = {1'b0, cnt_reg};
    assign j_x      = {1'b0, j_reg};
    assign j_m1     = j_reg - 1'b1;
    assign j_p1     = j_reg + 1'b1;
    assign idx_p1   = idx1[CW-1:0];
    assign fit      = rd_data.free && (rd_data.len >= want_reg);
    assign exact    = rd_data.len == want_reg;
    assign hit      = rd_data.off == key_reg;
    assign scan_end = idx_reg >= cnt_reg;
    assign full     = cnt_reg == CW'(MAX_BLOCKS);
    assign out_free = !ov_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:     state_next = S_IDLE;
            S_IDLE:     if (accept) state_next = S_SCAN_RD;
            S_SCAN_RD:  state_next = scan_end ? S_RESP : S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (!fit)
                        state_next = S_SCAN_RD;
                    else if (exact)
                        state_next = S_ALLOC_WR2;
                    else if (full)
                        state_next = S_RESP;
                    else if (cnt_x > idx1)
                        state_next = S_UP_RD;
                    else
                        state_next = S_ALLOC_WR;
                end
                else
                begin
                    state_next = hit ? S_MRG_RD : S_SCAN_RD;
                end
            end
            S_UP_RD:     state_next = S_UP_WR;
            S_UP_WR:     state_next = (j_x > idx1 + 1'b1) ? S_UP_RD : S_ALLOC_WR;
            S_ALLOC_WR:  state_next = S_ALLOC_WR2;
            S_ALLOC_WR2: state_next = S_RESP;
            S_MRG_RD:    state_next = (idx1 < cnt_x) ? S_MRG_CHK : S_FREE_WR;
            S_MRG_CHK:
            begin
                if (!rd_data.free)
                    state_next = S_FREE_WR;
                else if (idx1 + 1'b1 < cnt_x)
                    state_next = S_DN_RD;
                else
                    state_next = S_MRG_RD;
            end
            S_DN_RD:     state_next = S_DN_WR;
            S_DN_WR:     state_next = (j_x + 2'd2 < cnt_x) ? S_DN_RD : S_MRG_RD;
            S_FREE_WR:   state_next = S_RESP;
            S_RESP:      if (out_free) state_next = S_IDLE;
            default:     state_next = S_INIT;
        endcase
        if (reinit)
            state_next = S_INIT;
    end

    // table port and handshake outputs
    always_comb
    begin
        in_ready = state_reg == S_IDLE;
        rd_addr  = idx_reg[IW-1:0];
        wr_addr  = idx_reg[IW-1:0];
        wr       = '0;
        case (state_reg)
            S_INIT:
            begin
                wr_addr      = '0;
                wr.en        = 1'b1;
                wr.data.free = 1'b1;
                wr.data.len  = chunk;
                wr.data.off  = '0;
            end
            S_UP_RD:  rd_addr = j_m1[IW-1:0];
            S_UP_WR:
            begin
                wr_addr = j_reg[IW-1:0];
                wr.en   = 1'b1;
                wr.data = rd_data;
            end
            S_ALLOC_WR:
            begin
                wr_addr      = idx_p1[IW-1:0];
                wr.en        = 1'b1;
                wr.data.free = 1'b1;
                wr.data.len  = cur_reg.len - want_reg;
                wr.data.off  = cur_reg.off + want_reg;
            end
            S_ALLOC_WR2:
            begin
                wr.en        = 1'b1;
                wr.data.free = 1'b0;
                wr.data.len  = want_reg;
                wr.data.off  = cur_reg.off;
            end
            S_MRG_RD: rd_addr = idx_p1[IW-1:0];
            S_DN_RD:  rd_addr = j_p1[IW-1:0];
            S_DN_WR:
            begin
                wr_addr = j_reg[IW-1:0];
                wr.en   = 1'b1;
                wr.data = rd_data;
            end
            S_FREE_WR:
            begin
                wr.en   = 1'b1;
                wr.data = cur_reg;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        cmd_next     = cmd_reg;
        want_next    = want_reg;
        key_next     = key_reg;
        cur_next     = cur_reg;
        res_st_next  = res_st_reg;
        res_off_next = res_off_reg;
        res_len_next = res_len_reg;
        ov_next      = ov_reg;
        ost_next     = ost_reg;
        ooff_next    = ooff_reg;
        olen_next    = olen_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_INIT: cnt_next = CW'(1);
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = cmd_t'(command);
                    want_next = request_bytes;
                    key_next  = block_offset_in;
                    idx_next  = '0;
                end
            end
            S_SCAN_RD:
            begin
                if (scan_end)
                begin
                    res_st_next  = (cmd_reg == CMD_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
                    res_off_next = '0;
                    res_len_next = '0;
                end
            end
            S_SCAN_CHK:
            begin
                cur_next = rd_data;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (!fit)
                        idx_next = idx_p1;
                    else if (exact)
                    begin
                        res_st_next  = ST_OK;
                        res_off_next = rd_data.off;
                        res_len_next = want_reg;
                    end
                    else if (full)
                    begin
                        res_st_next  = ST_FULL;
                        res_off_next = '0;
                        res_len_next = '0;
                    end
                    else
                        j_next = cnt_reg;
                end
                else
                begin
                    cur_next.free = 1'b1;
                    if (!hit)
                        idx_next = idx_p1;
                end
            end
            S_UP_WR: j_next = j_m1;
            S_ALLOC_WR2:
            begin
                // an exact fit adds no remainder entry
                if (cur_reg.len != want_reg)
                    cnt_next = cnt_reg + 1'b1;
                res_st_next  = ST_OK;
                res_off_next = cur_reg.off;
                res_len_next = want_reg;
            end
            S_MRG_CHK:
            begin
                if (rd_data.free)
                begin
                    cur_next.len = cur_reg.len + rd_data.len;
                    j_next       = idx_p1;
                    if (!(idx1 + 1'b1 < cnt_x))
                        cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DN_WR:
            begin
                j_next = j_p1;
                if (!(j_x + 2'd2 < cnt_x))
                    cnt_next = cnt_reg - 1'b1;
            end
            S_FREE_WR:
            begin
                res_st_next  = ST_OK;
                res_off_next = '0;
                res_len_next = '0;
            end
            S_RESP:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    ost_next  = res_st_reg;
                    ooff_next = res_off_reg;
                    olen_next = res_len_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= CW'(1);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        j_reg       <= j_next;
        cmd_reg     <= cmd_next;
        want_reg    <= want_next;
        key_reg     <= key_next;
        cur_reg     <= cur_next;
        res_st_reg  <= res_st_next;
        res_off_reg <= res_off_next;
        res_len_reg <= res_len_next;
        ost_reg     <= ost_next;
        ooff_reg    <= ooff_next;
        olen_reg    <= olen_next;
    end

    assign out_valid      = ov_reg;
    assign status         = ost_reg;
    assign granted_offset = ooff_reg;
    assign granted_bytes  = olen_reg;
    assign count          = cnt_reg;
    assign stat.init      = state_reg == S_INIT;
    assign stat.busy      = state_reg != S_IDLE;

endmodule

@@ tb/sv/tb_first_fit_block_allocator.sv @@
// Testbench for the first-fit block allocator: table-driven and random requests
module tb_first_fit_block_allocator
    import ffba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK = MAX_BLOCKS_DEF;
    localparam int WATCHDOG_CYCLES = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [31:0] request_bytes;
    logic [31:0] block_offset_in;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] granted_bytes;

    first_fit_block_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .request_bytes(request_bytes), .block_offset_in(block_offset_in),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .granted_offset(granted_offset), .granted_bytes(granted_bytes)
    );

    typedef struct {
        status_t     st;
        logic [31:0] off;
        logic [31:0] len;
    } grant_t;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] bytes;
        logic [31:0] offs;
        logic        known;
        grant_t      res;
    } req_row_t;

    // shadow block table
    logic [31:0] blk_off [NBLK];
    logic [31:0] blk_len [NBLK];
    logic        blk_free [NBLK];
    int          blk_cnt;
    logic [31:0] chunk_size;

    grant_t grant_q[$];
    int     err_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     recv_hold;
    int     quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic void rebuild_table(input logic [31:0] size);
        for (int k = 0; k < NBLK; k++)
        begin
            blk_off[k] = '0;
            blk_len[k] = '0;
            blk_free[k] = 1'b0;
        end
        blk_len[0] = size;
        blk_free[0] = 1'b1;
        blk_cnt = 1;
        chunk_size = size;
    endfunction

    function automatic grant_t predict_grant(input cmd_t cmd, input logic [31:0] want,
                                             input logic [31:0] offs);
        grant_t g;
        int i;
        g.st = ST_NO_FIT;
        g.off = '0;
        g.len = '0;
        if (cmd == CMD_ALLOC)
        begin
            for (i = 0; i < blk_cnt; i++)
            begin
                if (blk_free[i] && blk_len[i] >= want)
                begin
                    if (blk_len[i] > want)
                    begin
                        if (blk_cnt >= NBLK)
                        begin
                            g.st = ST_FULL;
                            return g;
                        end
                        for (int j = blk_cnt; j > i + 1; j--)
                        begin
                            blk_off[j] = blk_off[j-1];
                            blk_len[j] = blk_len[j-1];
                            blk_free[j] = blk_free[j-1];
                        end
                        blk_off[i+1] = blk_off[i] + want;
                        blk_len[i+1] = blk_len[i] - want;
                        blk_free[i+1] = 1'b1;
                        blk_cnt++;
                    end
                    blk_len[i] = want;
                    blk_free[i] = 1'b0;
                    g.st = ST_OK;
                    g.off = blk_off[i];
                    g.len = want;
                    return g;
                end
            end
            return g;
        end
        for (i = 0; i < blk_cnt; i++)
            if (blk_off[i] == offs)
                break;
        if (i >= blk_cnt)
        begin
            g.st = ST_NOT_FOUND;
            return g;
        end
        blk_free[i] = 1'b1;
        // absorb following free blocks; bound checked first
        while (i + 1 < blk_cnt && blk_free[i+1])
        begin
            blk_len[i] = blk_len[i] + blk_len[i+1];
            for (int j = i + 1; j + 1 < blk_cnt; j++)
            begin
                blk_off[j] = blk_off[j+1];
                blk_len[j] = blk_len[j+1];
                blk_free[j] = blk_free[j+1];
            end
            blk_cnt--;
            blk_off[blk_cnt] = '0;
            blk_len[blk_cnt] = '0;
            blk_free[blk_cnt] = 1'b0;
        end
        g.st = ST_OK;
        return g;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * int'(idx));
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_CHUNK)
            rebuild_table(val);
        @(posedge clk);
    endtask

    // hold valid until the transfer; expectation is queued at acceptance
    task automatic send_req(input cmd_t cmd, input logic [31:0] bytes,
                            input logic [31:0] offs, input bit known,
                            input grant_t typed);
        grant_t g;
        while (($urandom_range(99) < send_idle_pct))
            @(posedge clk);
        in_valid <= 1'b1;
        command <= cmd;
        request_bytes <= bytes;
        block_offset_in <= offs;
        do
            @(posedge clk);
        while (!in_ready);
        g = predict_grant(cmd, bytes, offs);
        if (known && (g.st != typed.st || g.off != typed.off || g.len != typed.len))
            report_mismatch("table row vs predictor", {30'd0, g.st}, {30'd0, typed.st});
        grant_q.insert(grant_q.size(), g);
        in_valid <= 1'b0;
        // let valid drop before the next request
        @(posedge clk);
    endtask

    task automatic drain();
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // pick an offset that is likely a live block
    function automatic logic [31:0] pick_offset();
        int r;
        r = $urandom_range(99);
        if (r < 80 && blk_cnt > 0)
            return blk_off[$urandom_range(blk_cnt - 1)];
        if (r < 90)
            return blk_off[0] + 32'd1;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 32'($urandom_range(chunk_size > 64 ? 64 : chunk_size));
        if (r < 85)
            return 32'($urandom_range(4096)) << $urandom_range(12);
        if (r < 95)
            return chunk_size - 32'($urandom_range(3));
        return $urandom;
    endfunction

    task automatic random_phase(input int n, input int s_idle, input int r_idle);
        grant_t none;
        cmd_t c;
        none = '{ST_OK, '0, '0};
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int k = 0; k < n; k++)
        begin
            c = ($urandom_range(99) < 55) ? CMD_ALLOC : CMD_FREE;
            send_req(c, pick_size(), pick_offset(), 1'b0, none);
        end
    endtask

    // receiver side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grant_q.size() == 0)
                report_mismatch("unexpected result", {30'd0, status}, '0);
            else
            begin
                grant_t w;
                w = grant_q.pop_front();
                if (status != w.st)
                    report_mismatch("status", {30'd0, status}, {30'd0, w.st});
                if (granted_offset != w.off)
                    report_mismatch("granted_offset", granted_offset, w.off);
                if (granted_bytes != w.len)
                    report_mismatch("granted_bytes", granted_bytes, w.len);
            end
        end
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("tb_first_fit_block_allocator: errors");
            $finish;
        end
    end

    req_row_t rows[$];

    function automatic req_row_t mk(input cmd_t c, input logic [31:0] b,
                                    input logic [31:0] o, input bit k,
                                    input status_t s, input logic [31:0] go,
                                    input logic [31:0] gb);
        req_row_t r;
        r.cmd = c;
        r.bytes = b;
        r.offs = o;
        r.known = k;
        r.res = '{s, go, gb};
        return r;
    endfunction

    function automatic void add_row(input cmd_t c, input logic [31:0] b,
                                    input logic [31:0] o, input bit k,
                                    input status_t s, input logic [31:0] go,
                                    input logic [31:0] gb);
        rows.insert(rows.size(), mk(c, b, o, k, s, go, gb));
    endfunction

    initial
    begin
        grant_t none;
        none = '{ST_OK, '0, '0};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        command = CMD_ALLOC;
        request_bytes = '0;
        block_offset_in = '0;
        recv_hold = 1'b0;
        err_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rebuild_table(CHUNK_RESET);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: 64 MiB chunk
        add_row(CMD_ALLOC, 32'h4400_0000, 0, 1'b1, ST_NO_FIT, 0, 0);
        add_row(CMD_ALLOC, 32'd0, 0, 1'b1, ST_OK, 0, 0);
        add_row(CMD_ALLOC, 32'd256, 0, 1'b1, ST_OK, 0, 256);
        add_row(CMD_FREE, 0, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 0, 0);
        add_row(CMD_FREE, 0, 32'd0, 1'b1, ST_OK, 0, 0);
        add_row(CMD_FREE, 0, 32'd0, 1'b1, ST_OK, 0, 0);
        add_row(CMD_ALLOC, 32'hFFFF_FFFF, 0, 1'b1, ST_NO_FIT, 0, 0);
        add_row(CMD_ALLOC, CHUNK_RESET, 0, 1'b1, ST_NO_FIT, 0, 0);
        add_row(CMD_ALLOC, 32'd1, 0, 1'b1, ST_OK, 32'd256, 32'd1);
        add_row(CMD_FREE, 0, 32'd0, 1'b1, ST_OK, 0, 0);
        add_row(CMD_ALLOC, 32'd100, 0, 1'b0, ST_OK, 0, 0);
        add_row(CMD_ALLOC, 32'd200, 0, 1'b0, ST_OK, 0, 0);
        add_row(CMD_FREE, 0, 32'd100, 1'b0, ST_OK, 0, 0);
        add_row(CMD_FREE, 0, 32'd0, 1'b0, ST_OK, 0, 0);
        foreach (rows[k])
            send_req(rows[k].cmd, rows[k].bytes, rows[k].offs, rows[k].known, rows[k].res);
        drain();

        // extremes of the chunk register, and the ignored index
        write_reg(REG_CHUNK, 32'd0);
        write_reg(REG_NONE, 32'h1234_5678);
        send_req(CMD_ALLOC, 32'd1, 0, 1'b1, '{ST_NO_FIT, 32'd0, 32'd0});
        send_req(CMD_ALLOC, 32'd0, 0, 1'b1, '{ST_OK, 32'd0, 32'd0});
        drain();
        write_reg(REG_CHUNK, 32'hFFFF_FFFF);
        send_req(CMD_ALLOC, 32'hFFFF_FFFF, 0, 1'b1, '{ST_OK, 32'd0, 32'hFFFF_FFFF});
        send_req(CMD_FREE, 0, 32'd0, 1'b1, '{ST_OK, 32'd0, 32'd0});
        drain();

        // fill the table with unit blocks to reach the full case
        write_reg(REG_CHUNK, 32'd100);
        for (int k = 0; k < 66; k++)
            send_req(CMD_ALLOC, 32'd1, 0, 1'b0, none);
        drain();

        write_reg(REG_CHUNK, 32'd4096);
        random_phase(400, 36, 86);
        drain();
        write_reg(REG_CHUNK, 32'd1);
        random_phase(100, 86, 36);
        drain();
        write_reg(REG_CHUNK, 32'd3000);
        random_phase(300, 86, 36);
        // hold the receiver while requests pile up behind it
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
            random_phase(20, 0, 0);
        join
        // pause sender until every result has arrived
        drain();
        write_reg(REG_CHUNK, CHUNK_RESET);
        random_phase(400, 0, 0);
        drain();

        if (err_count == 0)
            $display("tb_first_fit_block_allocator: clean");
        else
            $display("tb_first_fit_block_allocator: errors");
        $finish;
    end
endmodule
